// ===== sv/lrsm_pkg.sv =====
// Shared widths, reset values and register indexes of the letterbox resize source mapper.
`default_nettype none

package lrsm_pkg;

  // Canvas coordinates, ROI positions and source coordinates.
  localparam int COORD_W    = 12;
  // Size registers as written through the configuration port.
  localparam int SIZE_REG_W = 13;
  localparam int PAD_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  // Width of the odd multiplier 2k+1 that scales the ROI size.
  localparam int MUL_W      = COORD_W + 1;
  // Register stages in one axis datapath.
  localparam int AXIS_LAT   = 6;

  localparam logic [SIZE_REG_W-1:0] RST_SIZE      = 13'd640;
  localparam logic [PAD_W-1:0]      RST_PAD       = 8'd114;
  localparam logic                  RST_LETTERBOX = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROI_LEFT,
    REG_ROI_TOP,
    REG_ROI_COLS,
    REG_ROI_ROWS,
    REG_MODEL_COLS,
    REG_MODEL_ROWS,
    REG_LETTERBOX,
    REG_PAD_BYTE
  } cfg_reg_e;

endpackage

`default_nettype wire

// ===== sv/lrsm_div.sv =====
// Shared restoring divider, one quotient bit per cycle, used for the geometry set-up.
`default_nettype none

module lrsm_div #(
  parameter int DVD_W = 28,
  parameter int DVS_W = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             clear_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             run_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             ge;

  // The dividend shifts out at the top while the quotient bits shift in at the bottom.
  assign rem_sh  = {rem_q, dvd_q[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (clear_i) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DVD_W);
    end else begin
      done_q <= run_q && (cnt_q == CNT_W'(1));
      if (run_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
      rem_q <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

`default_nettype wire

// ===== sv/lrsm_axis.sv =====
// Six-stage datapath that maps one canvas coordinate of one axis to a source coordinate.
`default_nettype none

module lrsm_axis #(
  parameter int SIZE_W = 13
) (
  input  logic                               clk_i,
  input  logic [lrsm_pkg::COORD_W-1:0]       coord_i,
  input  logic [SIZE_W-1:0]                  off_i,
  input  logic [SIZE_W-1:0]                  rsz_i,
  input  logic [SIZE_W-1:0]                  roi_size_i,
  input  logic [lrsm_pkg::MUL_W+SIZE_W-1:0]  recip_i,
  input  logic [lrsm_pkg::COORD_W-1:0]       base_i,
  output logic                               inside_o,
  output logic [lrsm_pkg::COORD_W-1:0]       src_o
);

  import lrsm_pkg::*;

  localparam int NW = MUL_W + SIZE_W;
  localparam int PW = 2 * NW;
  localparam int EW = ((SIZE_W > COORD_W) ? SIZE_W : COORD_W) + 1;

  logic [EW-1:0]       diff;
  logic                in_d;
  logic [SIZE_W:0]     dsz;
  logic [PW-1:0]       prod3;
  logic [NW-1:0]       rem5;
  logic                rem_ge;
  logic [SIZE_W-1:0]   lim;
  logic [SIZE_W-1:0]   idx;

  logic [AXIS_LAT-1:0] in_q;
  logic [MUL_W-1:0]    m1_q;
  logic [NW-1:0]       n2_q;
  logic [NW-1:0]       n3_q;
  logic [NW-1:0]       n4_q;
  logic [NW-1:0]       prod4_q;
  logic [SIZE_W-1:0]   q3_q;
  logic [SIZE_W-1:0]   q4_q;
  logic [SIZE_W-1:0]   q5_q;
  logic [COORD_W-1:0]  src_q;

  assign diff = EW'(coord_i) - EW'(off_i);
  assign in_d = (EW'(coord_i) >= EW'(off_i)) && (diff < EW'(rsz_i));
  assign dsz  = {rsz_i, 1'b0};

  // The reciprocal is floor(2^NW / dsz), so the estimate is the quotient or one below it.
  assign prod3  = PW'(n2_q) * PW'(recip_i);
  assign rem5   = n4_q - prod4_q;
  assign rem_ge = rem5 >= NW'(dsz);
  assign lim    = roi_size_i - SIZE_W'(1);
  assign idx    = (q5_q > lim) ? lim : q5_q;

  always_ff @(posedge clk_i) begin
    in_q    <= {in_q[AXIS_LAT-2:0], in_d};
    m1_q    <= {diff[COORD_W-1:0], 1'b1};
    n2_q    <= NW'(m1_q) * NW'(roi_size_i);
    n3_q    <= n2_q;
    q3_q    <= prod3[NW +: SIZE_W];
    n4_q    <= n3_q;
    q4_q    <= q3_q;
    prod4_q <= NW'(q3_q) * NW'(dsz);
    q5_q    <= q4_q + SIZE_W'(rem_ge);
    src_q   <= base_i + COORD_W'(idx);
  end

  assign inside_o = in_q[AXIS_LAT-1];
  assign src_o    = src_q;

endmodule

`default_nettype wire

// ===== sv/letterbox_resize_source_mapper.sv =====
// Top level of the letterbox resize source mapper: registers, geometry set-up and pipeline.
`default_nettype none

// Maps each pixel of the model input canvas to the source pixel that a nearest-neighbour
// resize samples there, or marks it as padding of the letterbox.
//
// Input beats arrive on canvas_x_i / canvas_y_i and are taken at a rising edge with start_i
// high and busy_o low. One beat can be taken in every cycle while busy_o is low. Each
// result beat is shown for exactly one cycle with result_valid_o high, once its input
// beat has passed the range check, scaling through three multipliers, a correction, the
// ROI offset and one output register. The receiver cannot hold results off, so the
// pipeline never stalls.
//
// The configuration channel (cfg_valid_i, cfg_index_i, cfg_data_i) is always ready. The
// letterbox geometry and the per-axis reciprocals depend only on the registers, so they
// are worked out once by a bit-serial divider: after reset and after every register write
// busy_o stays high through the clamp, multiply, compare and offset steps and the three
// divisions (two in stretch mode). Registers must only be rewritten while no results are
// outstanding; the block itself does not enforce it. Reset loads the register defaults
// and starts this set-up pass.

module letterbox_resize_source_mapper #(
  parameter int MAX_DIM = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [lrsm_pkg::COORD_W-1:0]      canvas_x_i,
  input  logic [lrsm_pkg::COORD_W-1:0]      canvas_y_i,
  output logic                              result_valid_o,
  output logic                              is_padding_o,
  output logic [lrsm_pkg::COORD_W-1:0]      src_col_o,
  output logic [lrsm_pkg::COORD_W-1:0]      src_row_o,
  output logic [lrsm_pkg::PAD_W-1:0]        fill_byte_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lrsm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lrsm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import lrsm_pkg::*;

  localparam int SIZE_W  = $clog2(MAX_DIM + 1);
  localparam int NW      = MUL_W + SIZE_W;
  localparam int PRD_W   = 2 * SIZE_W;
  localparam int DVS_W   = SIZE_W + 1;
  localparam int DVD_W   = ((NW + 1) > (2 * SIZE_W + 2)) ? (NW + 1) : (2 * SIZE_W + 2);
  localparam int OUT_LAT = AXIS_LAT + 1;

  localparam logic [DVD_W-1:0] RECIP_DVD = DVD_W'(1) << NW;

  // Geometry set-up sequencer.
  localparam logic [2:0] G_IDLE = 3'd0;
  localparam logic [2:0] G_CLP  = 3'd1;
  localparam logic [2:0] G_MUL  = 3'd2;
  localparam logic [2:0] G_CMP  = 3'd3;
  localparam logic [2:0] G_DSZ  = 3'd4;
  localparam logic [2:0] G_OFF  = 3'd5;
  localparam logic [2:0] G_DRX  = 3'd6;
  localparam logic [2:0] G_DRY  = 3'd7;

  function automatic logic [SIZE_W-1:0] clamp_dim(input logic [SIZE_REG_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) return SIZE_W'(1);
    if (w > 32'(MAX_DIM)) return SIZE_W'(MAX_DIM);
    return SIZE_W'(v);
  endfunction

  // Configuration registers.
  logic [COORD_W-1:0]    roi_left_q;
  logic [COORD_W-1:0]    roi_top_q;
  logic [SIZE_REG_W-1:0] roi_cols_q;
  logic [SIZE_REG_W-1:0] roi_rows_q;
  logic [SIZE_REG_W-1:0] model_cols_q;
  logic [SIZE_REG_W-1:0] model_rows_q;
  logic                  letterbox_q;
  logic [PAD_W-1:0]      pad_q;

  // Derived geometry.
  logic [SIZE_W-1:0] rc_q, rr_q, mc_q, mr_q;
  logic [PRD_W-1:0]  prod_a_q, prod_b_q;
  logic              wlim_q;
  logic [SIZE_W-1:0] rw_q, rh_q, offx_q, offy_q;
  logic [NW-1:0]     recx_q, recy_q;

  logic [2:0]        state_q, state_d;
  logic              cfg_acc;
  logic              in_acc;

  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic              div_done;
  logic [DVD_W-1:0]  div_quo;
  logic [SIZE_W-1:0] div_size;

  logic [AXIS_LAT-1:0] vld_q;
  logic                in_x, in_y;
  logic [COORD_W-1:0]  src_x, src_y;
  logic                pad;

  logic                res_vld_q;
  logic                is_pad_q;
  logic [COORD_W-1:0]  src_col_q, src_row_q;
  logic [PAD_W-1:0]    fill_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;
  // A pending register write also holds input beats off, so no beat is taken in the cycle of a write.
  assign busy_o      = (state_q != G_IDLE) | cfg_valid_i;
  assign in_acc      = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roi_left_q   <= '0;
      roi_top_q    <= '0;
      roi_cols_q   <= RST_SIZE;
      roi_rows_q   <= RST_SIZE;
      model_cols_q <= RST_SIZE;
      model_rows_q <= RST_SIZE;
      letterbox_q  <= RST_LETTERBOX;
      pad_q        <= RST_PAD;
    end else if (cfg_acc) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ROI_LEFT:   roi_left_q   <= cfg_data_i[COORD_W-1:0];
        REG_ROI_TOP:    roi_top_q    <= cfg_data_i[COORD_W-1:0];
        REG_ROI_COLS:   roi_cols_q   <= cfg_data_i[SIZE_REG_W-1:0];
        REG_ROI_ROWS:   roi_rows_q   <= cfg_data_i[SIZE_REG_W-1:0];
        REG_MODEL_COLS: model_cols_q <= cfg_data_i[SIZE_REG_W-1:0];
        REG_MODEL_ROWS: model_rows_q <= cfg_data_i[SIZE_REG_W-1:0];
        REG_LETTERBOX:  letterbox_q  <= cfg_data_i[0];
        REG_PAD_BYTE:   pad_q        <= cfg_data_i[PAD_W-1:0];
      endcase
    end
  end

  // The resized size along the free axis is round-half-up of the scaled ROI size, at least 1.
  assign div_size = (div_quo[SIZE_W-1:0] == '0) ? SIZE_W'(1) : div_quo[SIZE_W-1:0];

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    unique case (state_q)
      G_IDLE: state_d = G_IDLE;
      G_CLP:  state_d = G_MUL;
      G_MUL:  state_d = G_CMP;
      G_CMP: begin
        if (letterbox_q) begin
          div_start = 1'b1;
          if (prod_a_q <= prod_b_q) begin
            div_dvd = DVD_W'({prod_a_q, 1'b0}) + DVD_W'(rc_q);
            div_dvs = {rc_q, 1'b0};
          end else begin
            div_dvd = DVD_W'({prod_b_q, 1'b0}) + DVD_W'(rr_q);
            div_dvs = {rr_q, 1'b0};
          end
          state_d = G_DSZ;
        end else begin
          state_d = G_OFF;
        end
      end
      G_DSZ: begin
        if (div_done) state_d = G_OFF;
      end
      G_OFF: begin
        div_start = 1'b1;
        div_dvd   = RECIP_DVD;
        div_dvs   = {rw_q, 1'b0};
        state_d   = G_DRX;
      end
      G_DRX: begin
        if (div_done) begin
          div_start = 1'b1;
          div_dvd   = RECIP_DVD;
          div_dvs   = {rh_q, 1'b0};
          state_d   = G_DRY;
        end
      end
      G_DRY: begin
        if (div_done) state_d = G_IDLE;
      end
      default: state_d = G_CLP;
    endcase
    // Any register write restarts the set-up from the clamped sizes.
    if (cfg_acc) begin
      state_d   = G_CLP;
      div_start = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_CLP;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      G_CLP: begin
        rc_q <= clamp_dim(roi_cols_q);
        rr_q <= clamp_dim(roi_rows_q);
        mc_q <= clamp_dim(model_cols_q);
        mr_q <= clamp_dim(model_rows_q);
      end
      G_MUL: begin
        prod_a_q <= PRD_W'(mc_q) * PRD_W'(rr_q);
        prod_b_q <= PRD_W'(mr_q) * PRD_W'(rc_q);
      end
      G_CMP: begin
        wlim_q <= prod_a_q <= prod_b_q;
        rw_q   <= mc_q;
        rh_q   <= mr_q;
      end
      G_DSZ: begin
        if (div_done) begin
          if (wlim_q) begin
            rh_q <= div_size;
          end else begin
            rw_q <= div_size;
          end
        end
      end
      G_OFF: begin
        offx_q <= (mc_q - rw_q) >> 1;
        offy_q <= (mr_q - rh_q) >> 1;
      end
      G_DRX: begin
        if (div_done) recx_q <= div_quo[NW-1:0];
      end
      G_DRY: begin
        if (div_done) recy_q <= div_quo[NW-1:0];
      end
      default: ;
    endcase
  end

  lrsm_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .clear_i   (cfg_acc),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  // Both axes run in lock step; the valid bits travel alongside them.
  lrsm_axis #(
    .SIZE_W(SIZE_W)
  ) u_axis_x (
    .clk_i     (clk_i),
    .coord_i   (canvas_x_i),
    .off_i     (offx_q),
    .rsz_i     (rw_q),
    .roi_size_i(rc_q),
    .recip_i   (recx_q),
    .base_i    (roi_left_q),
    .inside_o  (in_x),
    .src_o     (src_x)
  );

  lrsm_axis #(
    .SIZE_W(SIZE_W)
  ) u_axis_y (
    .clk_i     (clk_i),
    .coord_i   (canvas_y_i),
    .off_i     (offy_q),
    .rsz_i     (rh_q),
    .roi_size_i(rr_q),
    .recip_i   (recy_q),
    .base_i    (roi_top_q),
    .inside_o  (in_y),
    .src_o     (src_y)
  );

  assign pad = ~(in_x & in_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[AXIS_LAT-2:0], in_acc};
      res_vld_q <= vld_q[AXIS_LAT-1];
    end
  end

  // A padding pixel reports source zero and carries the fill value.
  always_ff @(posedge clk_i) begin
    is_pad_q  <= pad;
    src_col_q <= pad ? '0 : src_x;
    src_row_q <= pad ? '0 : src_y;
    fill_q    <= pad ? pad_q : '0;
  end

  assign result_valid_o = res_vld_q;
  assign is_padding_o   = is_pad_q;
  assign src_col_o      = src_col_q;
  assign src_row_o      = src_row_q;
  assign fill_byte_o    = fill_q;

  // Every accepted beat yields exactly one result beat, after the axis stages and the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o == $past(in_acc, OUT_LAT))
    else $error("result beat does not match an accepted input beat");

  // The divider only reports a quotient while the sequencer waits for one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == G_DSZ || state_q == G_DRX || state_q == G_DRY))
    else $error("divider finished outside a division step");

  // Once set up, the resized area is non-empty and fits inside the canvas.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == G_IDLE |-> (rw_q != '0 && rh_q != '0 && rw_q <= mc_q && rh_q <= mr_q))
    else $error("resized area inconsistent with canvas size");

endmodule

`default_nettype wire
